// ----- src/audio_echo_tone_mixer_macros.svh -----
// Assertion macros shared by the audio echo/tone mixer RTL.
// Included by files that carry concurrent assertions; needs no package.
`ifndef AUDIO_ECHO_TONE_MIXER_MACROS_SVH
`define AUDIO_ECHO_TONE_MIXER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AETM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define AETM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AETM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define AETM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- src/aetm_pkg.sv -----
// Types and constants for the audio echo/tone mixer.
// No dependencies; used by the interfaces, the mixing core and the top level.
package aetm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 5;
    localparam int MODE_W    = 2;
    localparam int CFG_W     = GAIN_W;
    localparam int ROM_DEPTH = 32;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [MODE_W-1:0] {
        MODE_SILENCE = 2'd0,
        MODE_TONE    = 2'd1,
        MODE_ECHO    = 2'd2,
        MODE_MUTE    = 2'd3
    } mode_t;

    typedef enum logic {
        REG_MODE      = 1'b0,
        REG_ECHO_GAIN = 1'b1
    } reg_index_t;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 5'd4;

    typedef struct packed {
        mode_t             mode;
        logic [GAIN_W-1:0] echo_gain;
    } cfg_t;

    localparam logic signed [SAMPLE_W-1:0] SINE_ROM [ROM_DEPTH] = '{
            16'sd0,     16'sd1170,  16'sd2296,  16'sd3333,
            16'sd4242,  16'sd4988,  16'sd5543,  16'sd5884,
            16'sd6000,  16'sd5884,  16'sd5543,  16'sd4988,
            16'sd4242,  16'sd3333,  16'sd2296,  16'sd1170,
            16'sd0,    -16'sd1170, -16'sd2296, -16'sd3333,
           -16'sd4242, -16'sd4988, -16'sd5543, -16'sd5884,
           -16'sd6000, -16'sd5884, -16'sd5543, -16'sd4988,
           -16'sd4242, -16'sd3333, -16'sd2296, -16'sd1170
    };

endpackage

// ----- src/aetm_stream_if.sv -----
// Valid/ready stream interfaces for microphone samples and mixer results.
// Depends on aetm_pkg for field widths.
interface aetm_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [aetm_pkg::SAMPLE_W-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink (input valid, input in_sample, output ready);
endinterface

interface aetm_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [aetm_pkg::SAMPLE_W-1:0] out_sample;
    logic                                  half_done;
    logic [aetm_pkg::SAMPLE_W-1:0]        peak_level;

    modport source (output valid, output out_sample, output half_done, output peak_level,
                    input ready);
    modport sink (input valid, input out_sample, input half_done, input peak_level,
                  output ready);
endinterface

// ----- src/aetm_mix_core.sv -----
// Output sample selection: scaled echo with saturation, sine tone, or silence.
// Depends on aetm_pkg for the configuration struct and the sine table.
module aetm_mix_core (
    input  logic signed [aetm_pkg::SAMPLE_W-1:0] sample,
    input  logic [aetm_pkg::ROM_AW-1:0]          phase,
    input  aetm_pkg::cfg_t                       cfg,
    output logic signed [aetm_pkg::SAMPLE_W-1:0] mixed
);

    localparam int PROD_W = aetm_pkg::SAMPLE_W + aetm_pkg::GAIN_W + 1;

    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] scaled;
    logic signed [aetm_pkg::SAMPLE_W-1:0] echo;

    assign product = PROD_W'(sample) * PROD_W'($signed({1'b0, cfg.echo_gain}));
    assign biased  = product + $signed({{(PROD_W-2){1'b0}}, product[PROD_W-1],
                                        product[PROD_W-1]});
    assign scaled  = biased >>> 2;

    always_comb
    begin
        if (scaled > PROD_W'(aetm_pkg::SAMPLE_MAX)) begin
            echo = aetm_pkg::SAMPLE_MAX;
        end else if (scaled < PROD_W'(aetm_pkg::SAMPLE_MIN)) begin
            echo = aetm_pkg::SAMPLE_MIN;
        end else begin
            echo = scaled[aetm_pkg::SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        case (cfg.mode)
            aetm_pkg::MODE_ECHO: mixed = echo;
            aetm_pkg::MODE_TONE: mixed = aetm_pkg::SINE_ROM[phase];
            default:             mixed = '0;
        endcase
    end

endmodule

// ----- src/audio_echo_tone_mixer.sv -----
// Audio echo/tone mixer top level: configuration registers, frame counter,
// half-buffer peak meter and the two-register sample pipeline.
// Depends on aetm_pkg, the stream interfaces, aetm_mix_core and the macro header.

// One microphone sample is taken per transfer and one result leaves per sample,
// in order. The block accepts a sample in every cycle while results are taken;
// each sample passes first through the input register and then the result
// register. The frame position runs over FRAMES frames and half_done marks the
// last frame of each half, with the peak input magnitude of that half in
// peak_level (zero on other frames).
// Configuration writes are meant for times when no sample is in flight.
`include "audio_echo_tone_mixer_macros.svh"

module audio_echo_tone_mixer #(
    parameter int FRAMES = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [aetm_pkg::CFG_W-1:0]   cfg_data,
    aetm_sample_if.sink                  capture,
    aetm_result_if.source                playback
);

    localparam int POS_W = $clog2(FRAMES);
    localparam logic [POS_W-1:0] HALF_LAST = POS_W'(FRAMES / 2 - 1);
    localparam logic [POS_W-1:0] FULL_LAST = POS_W'(FRAMES - 1);

    aetm_pkg::cfg_t cfg_reg;

    logic                                  s1_valid_reg;
    logic                                  s1_valid_next;
    logic signed [aetm_pkg::SAMPLE_W-1:0] s1_sample_reg;

    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic signed [aetm_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                                  half_done_reg;
    logic [aetm_pkg::SAMPLE_W-1:0]        peak_level_reg;

    logic [POS_W-1:0]                     frame_pos_reg;
    logic [POS_W-1:0]                     frame_pos_next;
    logic [aetm_pkg::SAMPLE_W-1:0]        running_peak_reg;
    logic [aetm_pkg::SAMPLE_W-1:0]        running_peak_next;

    logic                                  out_free;
    logic                                  s1_move;
    logic                                  accept;
    logic                                  last_frame;
    logic [aetm_pkg::SAMPLE_W-1:0]        magnitude;
    logic [aetm_pkg::SAMPLE_W-1:0]        peak_cand;
    logic signed [aetm_pkg::SAMPLE_W-1:0] mixed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.mode      <= aetm_pkg::MODE_TONE;
            cfg_reg.echo_gain <= aetm_pkg::GAIN_RESET;
        end else if (cfg_write) begin
            case (aetm_pkg::reg_index_t'(cfg_index))
                aetm_pkg::REG_MODE:
                    cfg_reg.mode <= aetm_pkg::mode_t'(cfg_data[aetm_pkg::MODE_W-1:0]);
                aetm_pkg::REG_ECHO_GAIN:
                    cfg_reg.echo_gain <= cfg_data[aetm_pkg::GAIN_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign out_free      = !out_valid_reg || playback.ready;
    assign s1_move       = s1_valid_reg && out_free;
    assign capture.ready = !s1_valid_reg || s1_move;
    assign accept        = capture.valid && capture.ready;

    assign s1_valid_next  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (playback.ready ? 1'b0 : out_valid_reg);

    assign magnitude  = s1_sample_reg[aetm_pkg::SAMPLE_W-1]
                        ? aetm_pkg::SAMPLE_W'(-s1_sample_reg)
                        : aetm_pkg::SAMPLE_W'(s1_sample_reg);
    assign peak_cand  = (magnitude > running_peak_reg) ? magnitude : running_peak_reg;
    assign last_frame = (frame_pos_reg == HALF_LAST) || (frame_pos_reg == FULL_LAST);

    assign running_peak_next = last_frame ? '0 : peak_cand;
    assign frame_pos_next    = (frame_pos_reg == FULL_LAST) ? '0
                                                            : frame_pos_reg + POS_W'(1'b1);

    aetm_mix_core u_mix_core (
        .sample (s1_sample_reg),
        .phase  (frame_pos_reg[aetm_pkg::ROM_AW-1:0]),
        .cfg    (cfg_reg),
        .mixed  (mixed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            frame_pos_reg    <= '0;
            running_peak_reg <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_move) begin
                frame_pos_reg    <= frame_pos_next;
                running_peak_reg <= running_peak_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_sample_reg <= capture.in_sample;
        end
        if (s1_move) begin
            out_sample_reg <= mixed;
            half_done_reg  <= last_frame;
            peak_level_reg <= last_frame ? peak_cand : '0;
        end
    end

    assign playback.valid      = out_valid_reg;
    assign playback.out_sample = out_sample_reg;
    assign playback.half_done  = half_done_reg;
    assign playback.peak_level = peak_level_reg;

    `AETM_ASSERT_IMP(a_peak_only_on_half, clk, rst_n,
                     out_valid_reg && !half_done_reg, peak_level_reg == '0,
                     "peak reported outside a half boundary")
    `AETM_ASSERT_NEXT(a_peak_cleared, clk, rst_n,
                      s1_move && last_frame, running_peak_reg == '0,
                      "running peak not cleared after half boundary")
    `AETM_ASSERT_NEXT(a_result_loaded, clk, rst_n,
                      s1_move, out_valid_reg,
                      "result register empty after pipeline advance")
    `AETM_ASSERT_NEXT(a_stage_held, clk, rst_n,
                      s1_valid_reg && !out_free, s1_valid_reg && $stable(s1_sample_reg),
                      "input stage lost a sample while stalled")

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the audio echo/tone mixer: drives samples, predicts
// each mixed result with half-buffer peak tracking, and compares every transfer.
// Depends on aetm_pkg, the stream interfaces and the audio_echo_tone_mixer RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAMES = 256;

    typedef struct packed {
        logic signed [aetm_pkg::SAMPLE_W-1:0] out_sample;
        logic                                 half_done;
        logic [aetm_pkg::SAMPLE_W-1:0]        peak_level;
    } mix_result_t;

    localparam logic signed [aetm_pkg::SAMPLE_W-1:0] TONE_TABLE [aetm_pkg::ROM_DEPTH] = '{
            16'sd0,     16'sd1170,  16'sd2296,  16'sd3333,
            16'sd4242,  16'sd4988,  16'sd5543,  16'sd5884,
            16'sd6000,  16'sd5884,  16'sd5543,  16'sd4988,
            16'sd4242,  16'sd3333,  16'sd2296,  16'sd1170,
            16'sd0,    -16'sd1170, -16'sd2296, -16'sd3333,
           -16'sd4242, -16'sd4988, -16'sd5543, -16'sd5884,
           -16'sd6000, -16'sd5884, -16'sd5543, -16'sd4988,
           -16'sd4242, -16'sd3333, -16'sd2296, -16'sd1170
    };

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic                          cfg_index;
    logic [aetm_pkg::CFG_W-1:0]    cfg_data;

    aetm_sample_if capture_if ();
    aetm_result_if playback_if ();

    audio_echo_tone_mixer #(
        .FRAMES (FRAMES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .capture   (capture_if),
        .playback  (playback_if)
    );

    logic signed [aetm_pkg::SAMPLE_W-1:0] sample_queue [$];
    mix_result_t                          expected_mix [$];

    aetm_pkg::mode_t             cur_mode;
    logic [aetm_pkg::GAIN_W-1:0] cur_gain;
    int                          frame_pos;
    int                          half_peak;

    int mismatch_count;
    int tx_idle_pct;
    int rx_stall_pct;
    bit rx_hold;
    bit last_taken;

    always #6 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic mix_result_t mix_predict(
        input logic signed [aetm_pkg::SAMPLE_W-1:0] s);
        mix_result_t r;
        int          sv;
        int          mag;
        int          acc;
        bit          last;
        sv  = s;
        mag = (sv < 0) ? -sv : sv;
        if (mag > half_peak)
            half_peak = mag;
        case (cur_mode)
            aetm_pkg::MODE_ECHO:
            begin
                acc = (sv * int'(cur_gain)) / 4;
                if (acc > 32767)
                    acc = 32767;
                if (acc < -32768)
                    acc = -32768;
            end
            aetm_pkg::MODE_TONE: acc = TONE_TABLE[frame_pos % aetm_pkg::ROM_DEPTH];
            default:             acc = 0;
        endcase
        last = (frame_pos == FRAMES / 2 - 1) || (frame_pos == FRAMES - 1);
        r.out_sample = acc[aetm_pkg::SAMPLE_W-1:0];
        r.half_done  = last;
        r.peak_level = last ? half_peak[aetm_pkg::SAMPLE_W-1:0] : '0;
        if (last)
            half_peak = 0;
        frame_pos = (frame_pos + 1) % FRAMES;
        return r;
    endfunction

    function automatic logic signed [aetm_pkg::SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 4)
            return aetm_pkg::SAMPLE_MAX;
        else if (sel < 8)
            return aetm_pkg::SAMPLE_MIN;
        else if (sel < 12)
        begin
            logic signed [aetm_pkg::SAMPLE_W-1:0] tiny;
            tiny = aetm_pkg::SAMPLE_W'($urandom_range(6));
            return tiny - 16'sd3;
        end
        else if (sel < 35)
        begin
            logic [aetm_pkg::SAMPLE_W-1:0] mid;
            mid = aetm_pkg::SAMPLE_W'($urandom_range(4095));
            return $signed(mid) - 16'sd2048;
        end
        else
            return aetm_pkg::SAMPLE_W'($urandom);
    endfunction

    // Monitor: records input transfers into the predictor and checks output transfers.
    always @(posedge clk)
    begin
        mix_result_t want;
        if (rst_n)
        begin
            if (playback_if.valid && playback_if.ready)
            begin
                if (expected_mix.size() == 0)
                    report_mismatch("unexpected result, out_sample", playback_if.out_sample, 0);
                else
                begin
                    want = expected_mix.pop_front();
                    if (playback_if.out_sample !== want.out_sample)
                        report_mismatch("out_sample", playback_if.out_sample, want.out_sample);
                    if (playback_if.half_done !== want.half_done)
                        report_mismatch("half_done", playback_if.half_done, want.half_done);
                    if (playback_if.peak_level !== want.peak_level)
                        report_mismatch("peak_level", playback_if.peak_level, want.peak_level);
                end
            end
            last_taken = capture_if.valid && capture_if.ready;
            if (last_taken)
            begin
                expected_mix.push_back(mix_predict(capture_if.in_sample));
                void'(sample_queue.pop_front());
            end
        end
    end

    // Driver: a pending sample stays offered until its transfer completes.
    always @(negedge clk)
    begin
        if (!rst_n)
            capture_if.valid <= 1'b0;
        else if (capture_if.valid && !last_taken)
        begin
        end
        else if (sample_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct)
        begin
            capture_if.valid     <= 1'b1;
            capture_if.in_sample <= sample_queue[0];
        end
        else
        begin
            capture_if.valid     <= 1'b0;
            capture_if.in_sample <= aetm_pkg::SAMPLE_W'($urandom);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || rx_hold)
            playback_if.ready <= 1'b0;
        else
            playback_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic wait_drained();
        while (sample_queue.size() != 0 || expected_mix.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input aetm_pkg::reg_index_t idx,
                             input logic [aetm_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_data  <= aetm_pkg::CFG_W'($urandom);
        if (idx == aetm_pkg::REG_MODE)
            cur_mode = aetm_pkg::mode_t'(value[aetm_pkg::MODE_W-1:0]);
        else
            cur_gain = value;
    endtask

    task automatic set_config(input aetm_pkg::mode_t m, input logic [aetm_pkg::GAIN_W-1:0] g);
        logic [aetm_pkg::CFG_W-1:0] mode_word;
        wait_drained();
        mode_word = aetm_pkg::CFG_W'($urandom);
        mode_word[aetm_pkg::MODE_W-1:0] = m;
        write_reg(aetm_pkg::REG_MODE, mode_word);
        write_reg(aetm_pkg::REG_ECHO_GAIN, g);
    endtask

    task automatic push_samples(input logic signed [aetm_pkg::SAMPLE_W-1:0] vals[]);
        foreach (vals[i])
            sample_queue.push_back(vals[i]);
    endtask

    task automatic random_phase(input aetm_pkg::mode_t m,
                                input logic [aetm_pkg::GAIN_W-1:0] g, input int tx,
                                input int rx, input int count, input bit pressure);
        set_config(m, g);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        if (pressure)
        begin
            fork
                begin
                    rx_hold = 1'b1;
                    repeat (400) @(posedge clk);
                    rx_hold = 1'b0;
                end
            join_none
        end
        repeat (count)
            sample_queue.push_back(pick_sample());
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = aetm_pkg::REG_MODE;
        cfg_data       = '0;
        capture_if.valid     = 1'b0;
        capture_if.in_sample = '0;
        playback_if.ready    = 1'b0;
        mismatch_count = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        rx_hold        = 1'b0;
        last_taken     = 1'b0;
        cur_mode       = aetm_pkg::MODE_TONE;
        cur_gain       = aetm_pkg::GAIN_RESET;
        frame_pos      = 0;
        half_peak      = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_samples('{aetm_pkg::SAMPLE_MAX, aetm_pkg::SAMPLE_MIN, 16'sd0, 16'sd1, -16'sd1,
                       16'sh5555, 16'shAAAA, 16'sd1000});
        set_config(aetm_pkg::MODE_ECHO, 5'd31);
        push_samples('{aetm_pkg::SAMPLE_MAX, aetm_pkg::SAMPLE_MIN, 16'sd4227, -16'sd4228,
                       16'sd1234});
        set_config(aetm_pkg::MODE_ECHO, 5'd0);
        push_samples('{aetm_pkg::SAMPLE_MAX, aetm_pkg::SAMPLE_MIN});
        set_config(aetm_pkg::MODE_ECHO, 5'd1);
        push_samples('{-16'sd1, -16'sd3, -16'sd5, 16'sd3, 16'sd5});
        set_config(aetm_pkg::MODE_ECHO, 5'd16);
        push_samples('{aetm_pkg::SAMPLE_MAX, aetm_pkg::SAMPLE_MIN, 16'sd2047});
        set_config(aetm_pkg::MODE_SILENCE, 5'd4);
        push_samples('{aetm_pkg::SAMPLE_MAX, aetm_pkg::SAMPLE_MIN});
        set_config(aetm_pkg::MODE_MUTE, 5'd4);
        push_samples('{16'sd100});

        random_phase(aetm_pkg::MODE_ECHO, 5'd4, 0, 0, 150, 1'b0);
        random_phase(aetm_pkg::MODE_TONE, 5'd4, 58, 0, 120, 1'b0);
        random_phase(aetm_pkg::MODE_ECHO, 5'd17, 0, 58, 120, 1'b0);
        random_phase(aetm_pkg::mode_t'($urandom_range(3)), 5'($urandom_range(31)),
                     58, 58, 40, 1'b0);
        random_phase(aetm_pkg::MODE_ECHO, 5'($urandom_range(31)), 20, 20, 120, 1'b0);
        random_phase(aetm_pkg::MODE_ECHO, 5'd31, 0, 20, 120, 1'b1);
        random_phase(aetm_pkg::MODE_SILENCE, 5'd1, 20, 20, 40, 1'b0);
        random_phase(aetm_pkg::mode_t'($urandom_range(3)), 5'($urandom_range(31)),
                     0, 0, 60, 1'b0);

        wait_drained();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
